// ===== sv/nvd_pkg.sv =====
// Shared types and constants for the name/value pair stream decoder.
package nvd_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int LEN_W = 31;

	localparam logic [2:0] PH_NAME_LEN   = 3'd0;
	localparam logic [2:0] PH_NAME_EXT   = 3'd1;
	localparam logic [2:0] PH_VALUE_LEN  = 3'd2;
	localparam logic [2:0] PH_VALUE_EXT  = 3'd3;
	localparam logic [2:0] PH_NAME_DATA  = 3'd4;
	localparam logic [2:0] PH_VALUE_DATA = 3'd5;

	localparam logic [1:0] EXT_BYTES = 2'd3;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       ext;
	} nvd_item_t;

endpackage

// ===== sv/nvd_content_if.sv =====
// Content byte channel: valid/ready handshake with byte and last mark.
interface nvd_content_if;
	logic       valid;
	logic       ready;
	logic [7:0] content_byte;
	logic       content_last;

	modport source (output valid, output content_byte, output content_last, input ready);
	modport sink (input valid, input content_byte, input content_last, output ready);
endinterface

// ===== sv/nvd_pair_if.sv =====
// Decoded pair channel: valid/ready handshake with tagged payload byte and marks.
interface nvd_pair_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       in_value;
	logic       has_byte;
	logic       field_end;
	logic       pair_end;
	logic       truncated;

	modport source (output valid, output data_byte, output in_value, output has_byte,
		output field_end, output pair_end, output truncated, input ready);
	modport sink (input valid, input data_byte, input in_value, input has_byte,
		input field_end, input pair_end, input truncated, output ready);
endinterface

// ===== sv/nvd_front.sv =====
// Front end: takes content transfers, classifies length bytes, pushes to the queue.
module nvd_front
	import nvd_pkg::*;
(
	nvd_content_if.sink content,
	input  logic        full,
	output logic        push,
	output nvd_item_t   item
);

	assign content.ready = !full;
	assign push          = content.valid && !full;
	assign item.data     = content.content_byte;
	assign item.last     = content.content_last;
	assign item.ext      = content.content_byte[7];

endmodule

// ===== sv/nvd_queue.sv =====
// Short register queue between front end and decoder back end.
module nvd_queue
	import nvd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  nvd_item_t wr_item,
	input  logic      pop,
	output logic      full,
	output logic      not_empty,
	output nvd_item_t rd_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	nvd_item_t           mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/nvd_back.sv =====
// Back end: length/payload state machine and output register.
module nvd_back
	import nvd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        not_empty,
	input  nvd_item_t   item,
	output logic        pop,
	nvd_pair_if.source  pair
);

	logic [2:0]       phase_q, phase_n;
	logic [1:0]       lbl_q, lbl_n;
	logic [LEN_W-1:0] acc_q, acc_n;
	logic [LEN_W-1:0] name_q, name_n;
	logic [LEN_W-1:0] value_q, value_n;

	logic       emit, hasb, inval, fend, pend, trunc;
	logic [7:0] dbyte;

	logic       out_valid_q;
	logic [7:0] data_q;
	logic       in_value_q, has_byte_q, field_end_q, pair_end_q, truncated_q;

	assign pop = not_empty && (!out_valid_q || pair.ready);

	always_comb begin
		phase_n = phase_q;
		lbl_n   = lbl_q;
		acc_n   = acc_q;
		name_n  = name_q;
		value_n = value_q;
		emit    = 1'b0;
		hasb    = 1'b0;
		inval   = 1'b0;
		fend    = 1'b0;
		pend    = 1'b0;
		trunc   = 1'b0;
		dbyte   = '0;
		case (phase_q)
			PH_NAME_EXT, PH_VALUE_EXT: begin
				acc_n = {acc_q[LEN_W-9:0], item.data};
				lbl_n = lbl_q - 1'b1;
				if (lbl_q == 2'd1) begin
					if (phase_q == PH_NAME_EXT) begin
						name_n  = acc_n;
						phase_n = PH_VALUE_LEN;
					end else begin
						value_n = acc_n;
						if (name_q != '0) begin
							phase_n = PH_NAME_DATA;
						end else if (acc_n != '0) begin
							phase_n = PH_VALUE_DATA;
						end else begin
							phase_n = PH_NAME_LEN;
							emit    = 1'b1;
							pend    = 1'b1;
						end
					end
				end
			end
			PH_VALUE_LEN: begin
				if (item.ext) begin
					acc_n   = {{(LEN_W-7){1'b0}}, item.data[6:0]};
					lbl_n   = EXT_BYTES;
					phase_n = PH_VALUE_EXT;
				end else begin
					value_n = {{(LEN_W-8){1'b0}}, item.data};
					if (name_q != '0) begin
						phase_n = PH_NAME_DATA;
					end else if (item.data != '0) begin
						phase_n = PH_VALUE_DATA;
					end else begin
						phase_n = PH_NAME_LEN;
						emit    = 1'b1;
						pend    = 1'b1;
					end
				end
			end
			PH_NAME_DATA: begin
				emit   = 1'b1;
				hasb   = 1'b1;
				dbyte  = item.data;
				name_n = name_q - 1'b1;
				if (name_q == LEN_W'(1)) begin
					fend = 1'b1;
					if (value_q != '0) begin
						phase_n = PH_VALUE_DATA;
					end else begin
						pend    = 1'b1;
						phase_n = PH_NAME_LEN;
					end
				end
			end
			PH_VALUE_DATA: begin
				emit    = 1'b1;
				hasb    = 1'b1;
				inval   = 1'b1;
				dbyte   = item.data;
				value_n = value_q - 1'b1;
				if (value_q == LEN_W'(1)) begin
					fend    = 1'b1;
					pend    = 1'b1;
					phase_n = PH_NAME_LEN;
				end
			end
			default: begin
				if (item.ext) begin
					acc_n   = {{(LEN_W-7){1'b0}}, item.data[6:0]};
					lbl_n   = EXT_BYTES;
					phase_n = PH_NAME_EXT;
				end else begin
					name_n  = {{(LEN_W-8){1'b0}}, item.data};
					phase_n = PH_VALUE_LEN;
				end
			end
		endcase
		if (item.last) begin
			if (phase_n != PH_NAME_LEN) begin
				emit  = 1'b1;
				trunc = 1'b1;
			end
			phase_n = PH_NAME_LEN;
			lbl_n   = '0;
			acc_n   = '0;
			name_n  = '0;
			value_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_NAME_LEN;
			lbl_q       <= '0;
			acc_q       <= '0;
			name_q      <= '0;
			value_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_n;
				lbl_q   <= lbl_n;
				acc_q   <= acc_n;
				name_q  <= name_n;
				value_q <= value_n;
				out_valid_q <= emit;
			end else if (pair.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			data_q      <= dbyte;
			in_value_q  <= inval;
			has_byte_q  <= hasb;
			field_end_q <= fend;
			pair_end_q  <= pend;
			truncated_q <= trunc;
		end
	end

	assign pair.valid     = out_valid_q;
	assign pair.data_byte = data_q;
	assign pair.in_value  = in_value_q;
	assign pair.has_byte  = has_byte_q;
	assign pair.field_end = field_end_q;
	assign pair.pair_end  = pair_end_q;
	assign pair.truncated = truncated_q;

endmodule

// ===== sv/name_value_pair_stream_decoder.sv =====
// Name/value pair stream decoder: one content byte per cycle in unless the queue is
// full, tagged name and value bytes out. A front end takes each transfer into a short
// queue (QUEUE_DEPTH entries) and a back end decodes one queued byte per cycle into an
// output register while that register is empty or being taken. A transfer passes
// through the queue and the output register before its result can be taken; length
// bytes give no result unless they close an empty pair. Content that ends mid-pair
// gives a result with truncated set and the decoder expects a name length again.
module name_value_pair_stream_decoder
	import nvd_pkg::*;
#(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	nvd_content_if.sink content,
	nvd_pair_if.source  pair
);

	logic      full, push, pop, not_empty;
	nvd_item_t wr_item, rd_item;

	nvd_front u_front (
		.content (content),
		.full    (full),
		.push    (push),
		.item    (wr_item)
	);

	nvd_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_item   (wr_item),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.rd_item   (rd_item)
	);

	nvd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.item      (rd_item),
		.pop       (pop),
		.pair      (pair)
	);

endmodule

// ===== sv/nvd_checker.sv =====
// Port-level checks for the decoder, bound to the top level.
module nvd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] data_byte,
	input logic       in_value,
	input logic       has_byte,
	input logic       field_end,
	input logic       pair_end,
	input logic       truncated
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(in_value)
			&& $stable(has_byte) && $stable(field_end) && $stable(pair_end)
			&& $stable(truncated))
		else $error("result changed while stalled");

	a_fend_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_end |-> has_byte)
		else $error("field end without payload byte");

	a_empty_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> pair_end || truncated)
		else $error("empty result without pair end or truncation");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> data_byte == 8'd0 && !in_value)
		else $error("empty result carries payload");

endmodule

bind name_value_pair_stream_decoder nvd_checker u_nvd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (pair.valid),
	.out_ready (pair.ready),
	.data_byte (pair.data_byte),
	.in_value  (pair.in_value),
	.has_byte  (pair.has_byte),
	.field_end (pair.field_end),
	.pair_end  (pair.pair_end),
	.truncated (pair.truncated)
);

// ===== tb/name_value_pair_stream_decoder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the name/value pair stream decoder: directed table plus random records.
module name_value_pair_stream_decoder_tb
	import nvd_pkg::*;
();

	typedef struct packed {
		logic [7:0] data_byte;
		logic       in_value;
		logic       has_byte;
		logic       field_end;
		logic       pair_end;
		logic       truncated;
	} pair_res_t;

	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_QUIET,
		ROW_TYPED
	} row_kind_e;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
		row_kind_e  kind;
		pair_res_t  res;
	} content_xfer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	nvd_content_if content_ch();
	nvd_pair_if    pair_ch();

	name_value_pair_stream_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.content(content_ch),
		.pair   (pair_ch)
	);

	content_xfer_t content_q[$];
	pair_res_t     pair_expect_q[$];
	int            err_cnt = 0;
	int            src_idle_pct = 0;
	int            snk_idle_pct = 0;

	// decoder state as predicted
	logic [2:0]       dec_phase = PH_NAME_LEN;
	logic [1:0]       ext_left = '0;
	logic [LEN_W-1:0] len_accum = '0;
	logic [LEN_W-1:0] name_rem = '0;
	logic [LEN_W-1:0] value_rem = '0;

	content_xfer_t cur_xfer;
	pair_res_t     pred_res;
	pair_res_t     got_res;
	pair_res_t     want_res;

	content_xfer_t dir_tbl [0:24] = '{
		'{8'h00, 1'b0, ROW_QUIET, '0},
		'{8'h00, 1'b0, ROW_TYPED, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}},
		'{8'h01, 1'b0, ROW_QUIET, '0},
		'{8'h00, 1'b0, ROW_QUIET, '0},
		'{8'hff, 1'b0, ROW_TYPED, '{8'hff, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0}},
		'{8'h00, 1'b0, ROW_QUIET, '0},
		'{8'h01, 1'b0, ROW_QUIET, '0},
		'{8'h00, 1'b0, ROW_TYPED, '{8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0}},
		'{8'h02, 1'b0, ROW_QUIET, '0},
		'{8'h80, 1'b0, ROW_QUIET, '0},
		'{8'h00, 1'b0, ROW_QUIET, '0},
		'{8'h00, 1'b0, ROW_QUIET, '0},
		'{8'h01, 1'b0, ROW_QUIET, '0},
		'{8'ha5, 1'b0, ROW_PREDICT, '0},
		'{8'h5a, 1'b0, ROW_PREDICT, '0},
		'{8'h3c, 1'b0, ROW_PREDICT, '0},
		'{8'h7f, 1'b1, ROW_TYPED, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
		'{8'hff, 1'b0, ROW_QUIET, '0},
		'{8'hff, 1'b0, ROW_QUIET, '0},
		'{8'hff, 1'b0, ROW_QUIET, '0},
		'{8'hff, 1'b0, ROW_QUIET, '0},
		'{8'h00, 1'b0, ROW_QUIET, '0},
		'{8'h81, 1'b1, ROW_TYPED, '{8'h81, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1}},
		'{8'h00, 1'b0, ROW_QUIET, '0},
		'{8'h00, 1'b1, ROW_TYPED, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}}
	};

	initial begin
		forever #2 clk = ~clk;
	end

	// both lengths known: pick next phase, 1 on an empty pair
	function automatic bit pair_lengths_known();
		if (name_rem != '0) begin
			dec_phase = PH_NAME_DATA;
		end else if (value_rem != '0) begin
			dec_phase = PH_VALUE_DATA;
		end else begin
			dec_phase = PH_NAME_LEN;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit decode_content_byte(input logic [7:0] b, input logic last,
		output pair_res_t r);
		bit emit;
		emit = 1'b0;
		r = '0;
		case (dec_phase)
			PH_NAME_EXT, PH_VALUE_EXT: begin
				len_accum = {len_accum[LEN_W-9:0], b};
				ext_left = ext_left - 2'd1;
				if (ext_left == 2'd0) begin
					if (dec_phase == PH_NAME_EXT) begin
						name_rem = len_accum;
						dec_phase = PH_VALUE_LEN;
					end else begin
						value_rem = len_accum;
						emit = pair_lengths_known();
						r.pair_end = emit;
					end
				end
			end
			PH_VALUE_LEN: begin
				if (b[7]) begin
					len_accum = LEN_W'(b[6:0]);
					ext_left = EXT_BYTES;
					dec_phase = PH_VALUE_EXT;
				end else begin
					value_rem = LEN_W'(b);
					emit = pair_lengths_known();
					r.pair_end = emit;
				end
			end
			PH_NAME_DATA: begin
				emit = 1'b1;
				r.has_byte = 1'b1;
				r.data_byte = b;
				name_rem = name_rem - 1'b1;
				if (name_rem == '0) begin
					r.field_end = 1'b1;
					if (value_rem != '0) begin
						dec_phase = PH_VALUE_DATA;
					end else begin
						r.pair_end = 1'b1;
						dec_phase = PH_NAME_LEN;
					end
				end
			end
			PH_VALUE_DATA: begin
				emit = 1'b1;
				r.has_byte = 1'b1;
				r.in_value = 1'b1;
				r.data_byte = b;
				value_rem = value_rem - 1'b1;
				if (value_rem == '0) begin
					r.field_end = 1'b1;
					r.pair_end = 1'b1;
					dec_phase = PH_NAME_LEN;
				end
			end
			default: begin
				if (b[7]) begin
					len_accum = LEN_W'(b[6:0]);
					ext_left = EXT_BYTES;
					dec_phase = PH_NAME_EXT;
				end else begin
					name_rem = LEN_W'(b);
					dec_phase = PH_VALUE_LEN;
				end
			end
		endcase
		if (last) begin
			if (dec_phase != PH_NAME_LEN) begin
				emit = 1'b1;
				r.truncated = 1'b1;
			end
			dec_phase = PH_NAME_LEN;
			ext_left = '0;
			len_accum = '0;
			name_rem = '0;
			value_rem = '0;
		end
		return emit;
	endfunction

	function automatic int unsigned pick_len();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 20)
			return 0;
		if (r < 85)
			return $urandom_range(1, 6);
		return $urandom_range(7, 140);
	endfunction

	task automatic add_len(ref logic [7:0] seq[$], input int unsigned len, input bit long_form);
		if (len < 128 && !long_form) begin
			seq.insert(seq.size(), 8'(len));
		end else begin
			seq.insert(seq.size(), {1'b1, len[30:24]});
			seq.insert(seq.size(), len[23:16]);
			seq.insert(seq.size(), len[15:8]);
			seq.insert(seq.size(), len[7:0]);
		end
	endtask

	// one pair (or a burst of noise), with a clean end, a cut or no end mark
	task automatic queue_pair(inout int n);
		logic [7:0]  seq[$];
		int unsigned nlen, vlen, ndata;
		int          sel, cut;
		sel = $urandom_range(99);
		cut = -1;
		if (sel < 10) begin
			repeat ($urandom_range(1, 6))
				seq.insert(seq.size(), 8'($urandom));
			cut = seq.size() - 1;
		end else if (sel < 16) begin
			nlen = pick_len();
			vlen = pick_len();
			if ($urandom_range(1)) begin
				nlen = ($urandom & 32'h7fff_ffff) | 32'h0100_0000;
				ndata = $urandom_range(0, 4);
			end else begin
				vlen = ($urandom & 32'h7fff_ffff) | 32'h0100_0000;
				ndata = nlen + $urandom_range(0, 4);
			end
			add_len(seq, nlen, 1'b1);
			add_len(seq, vlen, 1'b1);
			repeat (ndata)
				seq.insert(seq.size(), 8'($urandom));
			cut = seq.size() - 1;
		end else begin
			nlen = pick_len();
			vlen = pick_len();
			add_len(seq, nlen, $urandom_range(3) == 0);
			add_len(seq, vlen, $urandom_range(3) == 0);
			repeat (nlen + vlen)
				seq.insert(seq.size(), 8'($urandom));
			sel = $urandom_range(99);
			if (sel < 15)
				cut = seq.size() - 1;
			else if (sel < 27)
				cut = $urandom_range(0, seq.size() - 2);
		end
		for (int i = 0; i < seq.size(); i++) begin
			content_q.insert(content_q.size(), '{seq[i], (i == cut), ROW_PREDICT, '0});
			n++;
		end
	endtask

	function automatic void check_field(string fname, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", fname, want, got);
			err_cnt++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			content_ch.valid <= 1'b0;
			content_ch.content_byte <= '0;
			content_ch.content_last <= 1'b0;
		end else begin
			if (content_ch.valid && content_ch.ready) begin
				if (decode_content_byte(cur_xfer.b, cur_xfer.last, pred_res) &&
					cur_xfer.kind == ROW_PREDICT)
					pair_expect_q.insert(pair_expect_q.size(), pred_res);
				if (cur_xfer.kind == ROW_TYPED)
					pair_expect_q.insert(pair_expect_q.size(), cur_xfer.res);
			end
			if (!content_ch.valid || content_ch.ready) begin
				if (content_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					cur_xfer = content_q.pop_front();
					content_ch.valid <= 1'b1;
					content_ch.content_byte <= cur_xfer.b;
					content_ch.content_last <= cur_xfer.last;
				end else begin
					content_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_ch.ready <= 1'b0;
		end else begin
			if (pair_ch.valid && pair_ch.ready) begin
				got_res = '{pair_ch.data_byte, pair_ch.in_value, pair_ch.has_byte,
					pair_ch.field_end, pair_ch.pair_end, pair_ch.truncated};
				if (pair_expect_q.size() == 0) begin
					$error("unexpected result transfer %0h", got_res);
					err_cnt++;
				end else begin
					want_res = pair_expect_q.pop_front();
					check_field("data_byte", want_res.data_byte, got_res.data_byte);
					check_field("in_value", 8'(want_res.in_value), 8'(got_res.in_value));
					check_field("has_byte", 8'(want_res.has_byte), 8'(got_res.has_byte));
					check_field("field_end", 8'(want_res.field_end),
						8'(got_res.field_end));
					check_field("pair_end", 8'(want_res.pair_end), 8'(got_res.pair_end));
					check_field("truncated", 8'(want_res.truncated),
						8'(got_res.truncated));
				end
			end
			pair_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	initial begin
		int n;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		for (int stage = 0; stage < 3; stage++) begin
			@(negedge clk);
			case (stage)
				0: begin
					src_idle_pct = 28;
					snk_idle_pct = 68;
					foreach (dir_tbl[i])
						content_q.insert(content_q.size(), dir_tbl[i]);
				end
				1: begin
					src_idle_pct = 68;
					snk_idle_pct = 28;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			n = 0;
			while (n < 300)
				queue_pair(n);
			while (content_q.size() != 0 || content_ch.valid)
				@(negedge clk);
			// sender holds off until the decoder has drained
			while (pair_expect_q.size() != 0)
				@(negedge clk);
		end
		repeat (20) @(negedge clk);
		if (err_cnt == 0)
			$display("name_value_pair_stream_decoder_tb: done, clean");
		else
			$display("name_value_pair_stream_decoder_tb: done, errors");
		$finish;
	end

	initial begin
		#2ms;
		$display("name_value_pair_stream_decoder_tb: done, errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/nvd_pkg.sv
sv/nvd_content_if.sv
sv/nvd_pair_if.sv
sv/nvd_front.sv
sv/nvd_queue.sv
sv/nvd_back.sv
sv/name_value_pair_stream_decoder.sv
sv/nvd_checker.sv
tb/name_value_pair_stream_decoder_tb.sv
